@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file hrp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/hrp_pkg.sv @@
// Types, codes and constants of the HTTP request header parser.
`default_nettype none

package hrp_pkg;

  localparam int unsigned LenW      = 17;
  localparam int unsigned CfgLenW   = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [CfgLenW-1:0] MaxMethodRst = CfgLenW'(20);
  localparam logic [CfgLenW-1:0] MaxKeyRst    = CfgLenW'(31);
  localparam logic [LenW-1:0]    MaxReqRst    = LenW'(32'h10000);

  localparam logic [CfgIdxW-1:0] REG_MAX_METHOD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_KEY    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_REQ    = 2'd2;

  localparam logic [2:0] KIND_SEP     = 3'd0;
  localparam logic [2:0] KIND_METHOD  = 3'd1;
  localparam logic [2:0] KIND_PATH    = 3'd2;
  localparam logic [2:0] KIND_QUERY   = 3'd3;
  localparam logic [2:0] KIND_KEY     = 3'd4;
  localparam logic [2:0] KIND_VALUE   = 3'd5;
  localparam logic [2:0] KIND_VERSION = 3'd6;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_METHOD_END = 3'd1;
  localparam logic [2:0] EV_RES_END    = 3'd2;
  localparam logic [2:0] EV_VER_END    = 3'd3;
  localparam logic [2:0] EV_KEY_END    = 3'd4;
  localparam logic [2:0] EV_VALUE_END  = 3'd5;
  localparam logic [2:0] EV_COMPLETE   = 3'd6;
  localparam logic [2:0] EV_ERROR      = 3'd7;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_METHOD_CHAR = 4'd1;
  localparam logic [3:0] ERR_METHOD_LEN  = 4'd2;
  localparam logic [3:0] ERR_CTRL_CHAR   = 4'd3;
  localparam logic [3:0] ERR_VER_CHAR    = 4'd4;
  localparam logic [3:0] ERR_VER_TEXT    = 4'd5;
  localparam logic [3:0] ERR_SUBVER      = 4'd6;
  localparam logic [3:0] ERR_KEY_CHAR    = 4'd7;
  localparam logic [3:0] ERR_KEY_LEN     = 4'd8;
  localparam logic [3:0] ERR_NO_LF       = 4'd9;
  localparam logic [3:0] ERR_TOO_LONG    = 4'd10;

  localparam logic [2:0] VerPrefixLen = 3'd6;
  localparam logic [2:0] VerMismatch  = 3'd7;

  typedef enum logic [3:0] {
    ST_METHOD   = 4'd0,
    ST_RESOURCE = 4'd1,
    ST_VERSION  = 4'd2,
    ST_SUBVER   = 4'd3,
    ST_KEY      = 4'd4,
    ST_SKIPSP   = 4'd5,
    ST_VALUE    = 4'd6,
    ST_LF       = 4'd7,
    ST_FINAL_LF = 4'd8
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [2:0]      byte_kind;
    logic [2:0]      event_res;
    logic [LenW-1:0] token_length;
    logic [3:0]      error_code;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic upper;
    logic lower;
    logic digit;
    logic space;
    logic ctrl;
    logic cr;
    logic lf;
    logic qmark;
    logic dot;
    logic colon;
    logic slash;
    logic dash;
    logic under;
    logic zero;
    logic one;
  } byte_class_t;

  typedef struct packed {
    in_item_t    item;
    byte_class_t cls;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hrp_front.sv @@
// Front end: input handshake and byte classification into the queue.
`default_nettype none

module hrp_front (
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire hrp_pkg::in_item_t  in_item_i,
  input  wire hrp_pkg::q_status_t q_stat_i,
  output logic                  push_o,
  output hrp_pkg::q_entry_t     entry_o
);
  import hrp_pkg::*;

  logic [7:0]  b;
  byte_class_t cls;

  assign b = in_item_i.data_byte;

  always_comb begin
    cls.upper = (b >= 8'h41) && (b <= 8'h5A);
    cls.lower = (b >= 8'h61) && (b <= 8'h7A);
    cls.digit = (b >= 8'h30) && (b <= 8'h39);
    cls.space = (b == 8'h20);
    cls.ctrl  = (b < 8'h20);
    cls.cr    = (b == 8'h0D);
    cls.lf    = (b == 8'h0A);
    cls.qmark = (b == 8'h3F);
    cls.dot   = (b == 8'h2E);
    cls.colon = (b == 8'h3A);
    cls.slash = (b == 8'h2F);
    cls.dash  = (b == 8'h2D);
    cls.under = (b == 8'h5F);
    cls.zero  = (b == 8'h30);
    cls.one   = (b == 8'h31);
  end

  assign in_ready_o    = !q_stat_i.full;
  assign push_o        = in_valid_i && !q_stat_i.full;
  assign entry_o.item  = in_item_i;
  assign entry_o.cls   = cls;

endmodule

`default_nettype wire

@@ rtl/core/hrp_fifo.sv @@
// Short queue between the classifier and the parser.
`default_nettype none

module hrp_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hrp_pkg::q_entry_t   entry_i,
  input  wire logic              pop_i,
  output hrp_pkg::q_entry_t      head_o,
  output hrp_pkg::q_status_t     stat_o
);
  import hrp_pkg::*;

  q_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full      = (cnt_q == QCntW'(QDepth));
  assign stat_o.not_empty = (cnt_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign head_o           = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hrp_back.sv @@
// Back end: request grammar state machine, limit registers, result register.
`default_nettype none

module hrp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hrp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hrp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire hrp_pkg::q_entry_t               head_i,
  input  wire hrp_pkg::q_status_t              q_stat_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output hrp_pkg::out_item_t                 out_item_o
);
  import hrp_pkg::*;

  logic [CfgLenW-1:0] max_meth_q, max_key_q;
  logic [LenW-1:0]    max_req_q;

  parse_state_e    state_q, state_d, s_eff;
  logic [LenW-1:0] bc_q, bc_d, bc_eff;
  logic [LenW-1:0] tc_q, tc_d, tc_eff;
  logic [2:0]      vm_q, vm_d, vm_eff;
  logic            iq_q, iq_d, iq_eff;
  logic            eh_q, eh_d, eh_eff;

  logic            out_valid_q;
  out_item_t       out_q, res;
  logic            fail, done;
  logic [LenW:0]   nc;
  logic [7:0]      b;
  byte_class_t     c;
  logic            rst_tok;

  assign b       = head_i.item.data_byte;
  assign c       = head_i.cls;
  assign rst_tok = head_i.item.restart;
  assign pop_o   = q_stat_i.not_empty && (!out_valid_q || out_ready_i);

  assign s_eff  = rst_tok ? ST_METHOD : state_q;
  assign bc_eff = rst_tok ? '0 : bc_q;
  assign tc_eff = rst_tok ? '0 : tc_q;
  assign vm_eff = rst_tok ? '0 : vm_q;
  assign iq_eff = rst_tok ? 1'b0 : iq_q;
  assign eh_eff = rst_tok ? 1'b0 : eh_q;
  assign nc     = {1'b0, bc_eff} + (LenW+1)'(1);

  // Result fields and counter updates.
  always_comb begin
    res.out_byte     = b;
    res.byte_kind    = KIND_SEP;
    res.event_res    = EV_NONE;
    res.token_length = '0;
    res.error_code   = ERR_NONE;
    res.last         = 1'b0;
    bc_d = bc_eff;
    tc_d = tc_eff;
    vm_d = vm_eff;
    iq_d = iq_eff;
    eh_d = eh_eff;
    fail = 1'b0;
    done = 1'b0;
    if (!eh_eff) begin
      if (nc > {1'b0, max_req_q}) begin
        fail = 1'b1;
        res.error_code = ERR_TOO_LONG;
      end else begin
        bc_d = nc[LenW-1:0];
        unique case (s_eff)
          ST_METHOD: begin
            if (c.space) begin
              if (tc_eff > LenW'(max_meth_q)) begin
                fail = 1'b1;
                res.error_code = ERR_METHOD_LEN;
              end else begin
                res.event_res    = EV_METHOD_END;
                res.token_length = tc_eff;
                tc_d = '0;
                iq_d = 1'b0;
              end
            end else if (c.upper || c.under) begin
              res.byte_kind = KIND_METHOD;
              tc_d = tc_eff + LenW'(1);
            end else begin
              fail = 1'b1;
              res.error_code = ERR_METHOD_CHAR;
            end
          end
          ST_RESOURCE: begin
            if (c.space) begin
              res.event_res    = EV_RES_END;
              res.token_length = tc_eff;
              tc_d = '0;
              vm_d = '0;
            end else if (c.ctrl) begin
              fail = 1'b1;
              res.error_code = ERR_CTRL_CHAR;
            end else begin
              if (c.qmark && !iq_eff) begin
                iq_d = 1'b1;
              end else begin
                res.byte_kind = iq_eff ? KIND_QUERY : KIND_PATH;
              end
              tc_d = tc_eff + LenW'(1);
            end
          end
          ST_VERSION: begin
            if (c.dot) begin
              if (vm_eff != VerPrefixLen) begin
                fail = 1'b1;
                res.error_code = ERR_VER_TEXT;
              end else begin
                res.byte_kind = KIND_VERSION;
                tc_d = tc_eff + LenW'(1);
                vm_d = '0;
              end
            end else if (c.upper || c.slash || c.one) begin
              if ((vm_eff < VerPrefixLen) && (b == version_char(vm_eff))) begin
                vm_d = vm_eff + 3'd1;
              end else begin
                vm_d = VerMismatch;
              end
              res.byte_kind = KIND_VERSION;
              tc_d = tc_eff + LenW'(1);
            end else begin
              fail = 1'b1;
              res.error_code = ERR_VER_CHAR;
            end
          end
          ST_SUBVER: begin
            if (c.lf || c.cr) begin
              res.event_res    = EV_VER_END;
              res.token_length = tc_eff;
              tc_d = '0;
            end else if ((c.zero || c.one) && (vm_eff == '0)) begin
              vm_d = 3'd1;
              res.byte_kind = KIND_VERSION;
              tc_d = tc_eff + LenW'(1);
            end else begin
              fail = 1'b1;
              res.error_code = ERR_SUBVER;
            end
          end
          ST_KEY: begin
            if (c.colon) begin
              res.event_res    = EV_KEY_END;
              res.token_length = tc_eff;
              tc_d = '0;
            end else if ((tc_eff == '0) && c.lf) begin
              done = 1'b1;
            end else if ((tc_eff == '0) && c.cr) begin
              // wait for the final LF
            end else if (tc_eff >= LenW'(max_key_q)) begin
              fail = 1'b1;
              res.error_code = ERR_KEY_LEN;
            end else if (c.upper) begin
              res.out_byte  = b + 8'd32;
              res.byte_kind = KIND_KEY;
              tc_d = tc_eff + LenW'(1);
            end else if (c.lower || c.digit || c.dash || c.under) begin
              res.byte_kind = KIND_KEY;
              tc_d = tc_eff + LenW'(1);
            end else begin
              fail = 1'b1;
              res.error_code = ERR_KEY_CHAR;
            end
          end
          ST_SKIPSP: begin
            if (!c.space) begin
              res.byte_kind = KIND_VALUE;
              tc_d = LenW'(1);
            end
          end
          ST_VALUE: begin
            if (!c.ctrl) begin
              res.byte_kind = KIND_VALUE;
              tc_d = tc_eff + LenW'(1);
            end else if (c.lf || c.cr) begin
              res.event_res    = EV_VALUE_END;
              res.token_length = tc_eff;
              tc_d = '0;
            end else begin
              fail = 1'b1;
              res.error_code = ERR_CTRL_CHAR;
            end
          end
          ST_LF: begin
            if (!c.lf) begin
              fail = 1'b1;
              res.error_code = ERR_NO_LF;
            end else begin
              tc_d = '0;
            end
          end
          ST_FINAL_LF: begin
            if (!c.lf) begin
              fail = 1'b1;
              res.error_code = ERR_NO_LF;
            end else begin
              done = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (fail) begin
        eh_d             = 1'b1;
        res.out_byte     = b;
        res.byte_kind    = KIND_SEP;
        res.event_res    = EV_ERROR;
        res.token_length = '0;
        res.last         = 1'b1;
      end else if (done) begin
        res.event_res    = EV_COMPLETE;
        res.token_length = nc[LenW-1:0];
        res.last         = 1'b1;
        bc_d = '0;
        tc_d = '0;
        vm_d = '0;
        iq_d = 1'b0;
        eh_d = 1'b0;
      end
    end
  end

  // Next parse state.
  always_comb begin
    state_d = s_eff;
    if (!eh_eff && !fail) begin
      if (done) begin
        state_d = ST_METHOD;
      end else begin
        unique case (s_eff)
          ST_METHOD:   if (c.space) state_d = ST_RESOURCE;
          ST_RESOURCE: if (c.space) state_d = ST_VERSION;
          ST_VERSION:  if (c.dot) state_d = ST_SUBVER;
          ST_SUBVER: begin
            if (c.cr) state_d = ST_LF;
            else if (c.lf) state_d = ST_KEY;
          end
          ST_KEY: begin
            if (c.colon) state_d = ST_SKIPSP;
            else if ((tc_eff == '0) && c.cr) state_d = ST_FINAL_LF;
          end
          ST_SKIPSP:   if (!c.space) state_d = ST_VALUE;
          ST_VALUE: begin
            if (c.cr) state_d = ST_LF;
            else if (c.lf) state_d = ST_KEY;
          end
          ST_LF:       state_d = ST_KEY;
          default:     state_d = s_eff;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_meth_q <= MaxMethodRst;
      max_key_q  <= MaxKeyRst;
      max_req_q  <= MaxReqRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_METHOD: max_meth_q <= cfg_wdata_i[CfgLenW-1:0];
        REG_MAX_KEY:    max_key_q  <= cfg_wdata_i[CfgLenW-1:0];
        REG_MAX_REQ:    max_req_q  <= cfg_wdata_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_METHOD;
      bc_q        <= '0;
      tc_q        <= '0;
      vm_q        <= '0;
      iq_q        <= 1'b0;
      eh_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q     <= state_d;
        bc_q        <= bc_d;
        tc_q        <= tc_d;
        vm_q        <= vm_d;
        iq_q        <= iq_d;
        eh_q        <= eh_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/http_request_header_parser_unit.sv @@
// Top level of the HTTP request header parser.
//
// Input channel: one request byte per transaction (data_byte, restart) on
// in_valid_i/in_ready_o. Output channel: one tagged result per input byte on
// out_valid_o/out_ready_i, in input order. restart returns the parser to the
// method state before its byte is parsed.
// The front end classifies each byte and writes it into a four-entry queue;
// the back end runs the grammar state machine on the queue head and holds
// the result in an output register.
// Each accepted byte waits in the queue until it reaches the head and the
// output register is free; its result is then registered there.
// Throughput: one byte per cycle, set by the state update of the back end;
// the queue and output register keep it while both sides flow.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ready_o drops once the four entries are taken.
// Reset clears the queue, parse state and counts and loads the limit
// registers with 20, 31 and 65536. The user writes limits through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while no transaction is in flight; not enforced.
`default_nettype none

module http_request_header_parser_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hrp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hrp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire hrp_pkg::in_item_t               in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output hrp_pkg::out_item_t                 out_item_o
);
  import hrp_pkg::*;

  q_status_t q_stat;
  q_entry_t  push_entry, head;
  logic      push, pop;

  hrp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  hrp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  hrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/hrp_checker.sv @@
// Port-level checks of the parser and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module hrp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire hrp_pkg::out_item_t  out_item_o
);
  import hrp_pkg::*;

  `HRP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  `HRP_ASSERT_NOW(a_last_ev, clk_i, rst_ni, out_valid_o && out_item_o.last, (out_item_o.event_res == EV_COMPLETE) || (out_item_o.event_res == EV_ERROR))
  `HRP_ASSERT_NOW(a_err_code, clk_i, rst_ni, out_valid_o, (out_item_o.error_code != ERR_NONE) == (out_item_o.event_res == EV_ERROR))
  `HRP_ASSERT_NOW(a_err_sep, clk_i, rst_ni, out_valid_o && (out_item_o.event_res == EV_ERROR), out_item_o.last && (out_item_o.byte_kind == KIND_SEP) && (out_item_o.token_length == '0))

endmodule

bind http_request_header_parser_unit hrp_checker u_hrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the HTTP request header parser: directed bytes, then random requests, predicted.
`timescale 1ns / 100ps

module tb_top;
  import hrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned N_PHASES    = 6;

  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_SP = 8'h20;

  localparam logic [47:0]  VER_TAG    = "HTTP/1";
  localparam logic [215:0] METHOD_SET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam logic [511:0] KEY_SET    =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef struct packed {
    logic [CfgLenW-1:0] m;
    logic [CfgLenW-1:0] k;
    logic [LenW-1:0]    r;
  } limits_t;

  localparam limits_t PHASE_LIMITS [0:4] = '{
    '{6'd1,  6'd1,  17'h10000},
    '{6'd63, 6'd63, 17'h10000},
    '{6'd8,  6'd4,  17'd48},
    '{6'd20, 6'd31, 17'd1},
    '{6'd63, 6'd2,  17'd17}
  };

  typedef struct packed {
    logic [7:0] b;
    logic       rs;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  localparam out_item_t NOT_TYPED = '0;

  localparam dir_row_t DIR_ROWS [0:24] = '{
    '{"G",   1'b1, 1'b1, '{"G", KIND_METHOD, EV_NONE, 17'd0, ERR_NONE, 1'b0}},
    '{"E",   1'b0, 1'b0, NOT_TYPED},
    '{"T",   1'b0, 1'b0, NOT_TYPED},
    '{" ",   1'b0, 1'b1, '{" ", KIND_SEP, EV_METHOD_END, 17'd3, ERR_NONE, 1'b0}},
    '{"/",   1'b0, 1'b0, NOT_TYPED},
    '{"?",   1'b0, 1'b0, NOT_TYPED},
    '{8'hFF, 1'b0, 1'b0, NOT_TYPED},
    '{" ",   1'b0, 1'b0, NOT_TYPED},
    '{"H",   1'b0, 1'b0, NOT_TYPED},
    '{"T",   1'b0, 1'b0, NOT_TYPED},
    '{"T",   1'b0, 1'b0, NOT_TYPED},
    '{"P",   1'b0, 1'b0, NOT_TYPED},
    '{"/",   1'b0, 1'b0, NOT_TYPED},
    '{"1",   1'b0, 1'b0, NOT_TYPED},
    '{".",   1'b0, 1'b0, NOT_TYPED},
    '{"1",   1'b0, 1'b0, NOT_TYPED},
    '{8'h0D, 1'b0, 1'b0, NOT_TYPED},
    '{8'h0A, 1'b0, 1'b0, NOT_TYPED},
    '{"A",   1'b0, 1'b1, '{"a", KIND_KEY, EV_NONE, 17'd0, ERR_NONE, 1'b0}},
    '{":",   1'b0, 1'b0, NOT_TYPED},
    '{8'h0A, 1'b0, 1'b0, NOT_TYPED},
    '{8'h0A, 1'b0, 1'b0, NOT_TYPED},
    '{8'h0A, 1'b0, 1'b1, '{8'h0A, KIND_SEP, EV_COMPLETE, 17'd23, ERR_NONE, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, KIND_SEP, EV_ERROR, 17'd0, ERR_METHOD_CHAR, 1'b1}},
    '{"A",   1'b0, 1'b1, '{"A", KIND_SEP, EV_NONE, 17'd0, ERR_NONE, 1'b0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;

  http_request_header_parser_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [CfgLenW-1:0] lim_method, lim_key;
  logic [LenW-1:0]    lim_bytes;
  parse_state_e       ps;
  logic [LenW-1:0]    nbytes, tok_len;
  logic [2:0]         ver_pos;
  logic               seen_q, halted;

  out_item_t   results_due [$];
  in_item_t    byte_plan [$];

  int unsigned n_sent, n_checked, n_bad, n_complete, n_error;
  logic        tx_calm, rx_calm, squeeze_on, squeeze_done;

  function automatic void clear_ctx();
    ps      = ST_METHOD;
    nbytes  = '0;
    tok_len = '0;
    ver_pos = '0;
    seen_q  = 1'b0;
    halted  = 1'b0;
  endfunction

  function automatic out_item_t parse_byte(input in_item_t it);
    logic [7:0]  b;
    logic [17:0] nxt;
    logic        fail;
    out_item_t   r;
    b = it.data_byte;
    r = '0;
    r.out_byte = b;
    fail = 1'b0;
    if (it.restart) clear_ctx();
    if (halted) return r;
    nxt = {1'b0, nbytes} + 18'd1;
    if (nxt > {1'b0, lim_bytes}) begin
      r.error_code = ERR_TOO_LONG;
      fail = 1'b1;
    end else begin
      nbytes = nxt[LenW-1:0];
      case (ps)
        ST_METHOD: begin
          if (b == CHR_SP) begin
            if (tok_len > lim_method) begin
              r.error_code = ERR_METHOD_LEN;
              fail = 1'b1;
            end else begin
              r.event_res = EV_METHOD_END;
              r.token_length = tok_len;
              tok_len = '0;
              seen_q = 1'b0;
              ps = ST_RESOURCE;
            end
          end else if ((b >= "A" && b <= "Z") || b == "_") begin
            r.byte_kind = KIND_METHOD;
            tok_len++;
          end else begin
            r.error_code = ERR_METHOD_CHAR;
            fail = 1'b1;
          end
        end
        ST_RESOURCE: begin
          if (b == CHR_SP) begin
            r.event_res = EV_RES_END;
            r.token_length = tok_len;
            tok_len = '0;
            ver_pos = '0;
            ps = ST_VERSION;
          end else if (b < 8'd32) begin
            r.error_code = ERR_CTRL_CHAR;
            fail = 1'b1;
          end else begin
            if (b == "?" && !seen_q) begin
              seen_q = 1'b1;
              r.byte_kind = KIND_SEP;
            end else begin
              r.byte_kind = seen_q ? KIND_QUERY : KIND_PATH;
            end
            tok_len++;
          end
        end
        ST_VERSION: begin
          if (b == ".") begin
            if (ver_pos != 3'd6) begin
              r.error_code = ERR_VER_TEXT;
              fail = 1'b1;
            end else begin
              r.byte_kind = KIND_VERSION;
              tok_len++;
              ver_pos = '0;
              ps = ST_SUBVER;
            end
          end else if ((b >= "A" && b <= "Z") || b == "/" || b == "1") begin
            if (ver_pos < 3'd6 && b == VER_TAG[8*(5-int'(ver_pos)) +: 8]) ver_pos++;
            else ver_pos = 3'd7;
            r.byte_kind = KIND_VERSION;
            tok_len++;
          end else begin
            r.error_code = ERR_VER_CHAR;
            fail = 1'b1;
          end
        end
        ST_SUBVER: begin
          if (b == CHR_LF || b == CHR_CR) begin
            r.event_res = EV_VER_END;
            r.token_length = tok_len;
            tok_len = '0;
            ps = (b == CHR_CR) ? ST_LF : ST_KEY;
          end else if ((b == "0" || b == "1") && ver_pos == 3'd0) begin
            ver_pos = 3'd1;
            r.byte_kind = KIND_VERSION;
            tok_len++;
          end else begin
            r.error_code = ERR_SUBVER;
            fail = 1'b1;
          end
        end
        ST_KEY: begin
          if (b == ":") begin
            r.event_res = EV_KEY_END;
            r.token_length = tok_len;
            tok_len = '0;
            ps = ST_SKIPSP;
          end else if (tok_len == 0 && b == CHR_LF) begin
            r.event_res = EV_COMPLETE;
            r.token_length = nbytes;
            r.last = 1'b1;
            clear_ctx();
          end else if (tok_len == 0 && b == CHR_CR) begin
            ps = ST_FINAL_LF;
          end else if (tok_len >= lim_key) begin
            r.error_code = ERR_KEY_LEN;
            fail = 1'b1;
          end else if (b >= "A" && b <= "Z") begin
            r.out_byte = b + 8'd32;
            r.byte_kind = KIND_KEY;
            tok_len++;
          end else if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
                       b == "-" || b == "_") begin
            r.byte_kind = KIND_KEY;
            tok_len++;
          end else begin
            r.error_code = ERR_KEY_CHAR;
            fail = 1'b1;
          end
        end
        ST_SKIPSP: begin
          if (b != CHR_SP) begin
            r.byte_kind = KIND_VALUE;
            tok_len = 17'd1;
            ps = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (b >= 8'd32) begin
            r.byte_kind = KIND_VALUE;
            tok_len++;
          end else if (b == CHR_LF || b == CHR_CR) begin
            r.event_res = EV_VALUE_END;
            r.token_length = tok_len;
            tok_len = '0;
            ps = (b == CHR_CR) ? ST_LF : ST_KEY;
          end else begin
            r.error_code = ERR_CTRL_CHAR;
            fail = 1'b1;
          end
        end
        ST_LF: begin
          if (b != CHR_LF) begin
            r.error_code = ERR_NO_LF;
            fail = 1'b1;
          end else begin
            tok_len = '0;
            ps = ST_KEY;
          end
        end
        ST_FINAL_LF: begin
          if (b != CHR_LF) begin
            r.error_code = ERR_NO_LF;
            fail = 1'b1;
          end else begin
            r.event_res = EV_COMPLETE;
            r.token_length = nbytes;
            r.last = 1'b1;
            clear_ctx();
          end
        end
        default: ;
      endcase
    end
    if (fail) begin
      halted = 1'b1;
      r.out_byte = b;
      r.byte_kind = KIND_SEP;
      r.event_res = EV_ERROR;
      r.token_length = '0;
      r.last = 1'b1;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic drive_byte(input in_item_t it, input logic typed, input out_item_t want);
    int unsigned gap;
    out_item_t   pred;
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    gap = (tx_calm || squeeze_on) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pred = parse_byte(it);
    results_due.insert(results_due.size(), typed ? want : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_limits(input limits_t lim);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MAX_METHOD;
    cfg_wdata_i <= CfgDataW'(lim.m);
    @(negedge clk_i);
    cfg_idx_i   <= REG_MAX_KEY;
    cfg_wdata_i <= CfgDataW'(lim.k);
    @(negedge clk_i);
    cfg_idx_i   <= REG_MAX_REQ;
    cfg_wdata_i <= CfgDataW'(lim.r);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_method = lim.m;
    lim_key    = lim.k;
    lim_bytes  = lim.r;
    @(negedge clk_i);
  endtask

  task automatic put(input logic [7:0] b);
    in_item_t t;
    t.data_byte = b;
    t.restart   = 1'b0;
    byte_plan.insert(byte_plan.size(), t);
  endtask

  task automatic put_eol();
    if ($urandom_range(0, 1)) put(CHR_CR);
    put(CHR_LF);
  endtask

  // one request, mostly well formed, sometimes with noise ahead, a bad byte or a cut tail
  task automatic plan_request();
    int unsigned n, k, start;
    in_item_t    t;
    byte_plan.delete();
    if ($urandom_range(0, 11) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        t.data_byte = 8'($urandom_range(0, 255));
        t.restart   = 1'($urandom_range(0, 1));
        byte_plan.insert(byte_plan.size(), t);
      end
    end
    start = byte_plan.size();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, lim_method + 2) : $urandom_range(1, 7);
    repeat (n) begin
      k = $urandom_range(0, 26);
      put(METHOD_SET[8*k +: 8]);
    end
    put(CHR_SP);
    n = $urandom_range(0, 8);
    repeat (n) put(($urandom_range(0, 5) == 0) ? "?" : 8'($urandom_range(33, 255)));
    put(CHR_SP);
    for (k = 0; k < 6; k++) put(VER_TAG[8*(5-k) +: 8]);
    put(".");
    case ($urandom_range(0, 2))
      0: put("0");
      1: put("1");
      default: ;
    endcase
    put_eol();
    repeat ($urandom_range(0, 3)) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, lim_key + 1) : $urandom_range(0, 6);
      repeat (n) begin
        k = $urandom_range(0, 63);
        put(KEY_SET[8*k +: 8]);
      end
      put(":");
      repeat ($urandom_range(0, 2)) put(CHR_SP);
      case ($urandom_range(0, 7))
        0: put(CHR_CR);
        1: put(CHR_LF);
        default: put(8'($urandom_range(33, 255)));
      endcase
      n = $urandom_range(0, 8);
      repeat (n) put(8'($urandom_range(32, 255)));
      put_eol();
    end
    put_eol();
    byte_plan[start].restart = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(start, byte_plan.size() - 1);
      byte_plan[k].data_byte = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                    : 8'("A" + $urandom_range(0, 25));
    end
    if ($urandom_range(0, 9) == 0 && byte_plan.size() >= start + 2) begin
      k = $urandom_range(start + 1, byte_plan.size() - 1);
      while (byte_plan.size() > k) void'(byte_plan.pop_back());
    end
  endtask

  initial begin : stimulus
    dir_row_t    row;
    in_item_t    t;
    int unsigned sent_in_phase;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    squeeze_on   = 1'b0;
    squeeze_done = 1'b0;
    n_sent = 0; n_checked = 0; n_bad = 0; n_complete = 0; n_error = 0;
    lim_method = MaxMethodRst;
    lim_key    = MaxKeyRst;
    lim_bytes  = MaxReqRst;
    clear_ctx();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      row = DIR_ROWS[i];
      t.data_byte = row.b;
      t.restart   = row.rs;
      drive_byte(t, row.typed, row.want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        in_valid_i <= 1'b0;
        while (results_due.size() != 0) @(posedge clk_i);
        repeat (4) @(negedge clk_i);
        write_limits(PHASE_LIMITS[p-1]);
      end
      sent_in_phase = 0;
      while (sent_in_phase < PHASE_ITEMS) begin
        plan_request();
        while (byte_plan.size() != 0) begin
          drive_byte(byte_plan.pop_front(), 1'b0, NOT_TYPED);
          sent_in_phase++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("tb_top: %0d bytes over %0d limit settings, %0d results compared",
             n_sent, N_PHASES, n_checked);
    $display("tb_top: %0d requests completed, %0d errors flagged, %0d mismatches",
             n_complete, n_error, n_bad);
    if (n_bad == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stall;
    out_item_t   got, want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (!squeeze_done && n_checked >= 400 && in_valid_i) begin
        squeeze_on = 1'b1;
        stall = 300;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        if (squeeze_on) begin
          squeeze_on   = 1'b0;
          squeeze_done = 1'b1;
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = out_item_o;
      if (results_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("tb_top: result with none pending: %h", got);
      end else begin
        want = results_due.pop_front();
        n_checked++;
        if (want.event_res == EV_COMPLETE) n_complete++;
        if (want.event_res == EV_ERROR) n_error++;
        if (got.out_byte !== want.out_byte || got.byte_kind !== want.byte_kind ||
            got.event_res !== want.event_res || got.token_length !== want.token_length ||
            got.error_code !== want.error_code || got.last !== want.last) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("tb_top: mismatch at result %0d: got b=%h k=%0d ev=%0d len=%0d c=%0d l=%0d",
                     n_checked, got.out_byte, got.byte_kind, got.event_res,
                     got.token_length, got.error_code, got.last);
            $display("tb_top:   expected b=%h k=%0d ev=%0d len=%0d c=%0d l=%0d",
                     want.out_byte, want.byte_kind, want.event_res,
                     want.token_length, want.error_code, want.last);
          end
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("tb_top: cycle limit reached, %0d results still pending", results_due.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
